FILE: rtl/jet_pkg.sv
// Shared types, constants and helpers for the Julia escape-time block.
package jet_pkg;

   // Fixed field and datapath widths.
   localparam int COORD_W = 32;
   localparam int STEP_W  = 31;
   localparam int IDX_W   = 12;
   localparam int LEVEL_W = 8;
   localparam int PROD_W  = 64;
   localparam int SPAN_W  = IDX_W + STEP_W;

   // Defaults for the top-level parameters.
   localparam int MAX_PASSES_DEF = 256;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int INDEX_BITS_DEF = 12;

   // Register interface.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_C_REAL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_C_IMAG    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_RE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_IM = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_RE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_IM   = 3'd5;

   localparam logic signed [COORD_W-1:0] C_REAL_RST    = -32'sd214748365;
   localparam logic signed [COORD_W-1:0] C_IMAG_RST    = -32'sd41875931;
   localparam logic signed [COORD_W-1:0] ORIGIN_RE_RST = -32'sd536870912;
   localparam logic signed [COORD_W-1:0] ORIGIN_IM_RST = -32'sd536870912;
   localparam logic [STEP_W-1:0]         STEP_RE_RST   = 31'd2097152;
   localparam logic [STEP_W-1:0]         STEP_IM_RST   = 31'd2097152;

   // Queue between the front end and the iteration engine.
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] zr;
      logic signed [COORD_W-1:0] zi;
   } point_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   // Clamp a wide two's complement value to the signed coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-COORD_W:0] top;
      top = v[PROD_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
         return v[COORD_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: rtl/julia_escape_time_top.sv
// Top level of the Julia escape-time block: register file and engine wiring.
//
// Each pixel beat (column, row) is turned into a registered start point by the
// front end and parked in a two-entry queue; the iteration engine then runs each
// pass as a product state for the three 32x32 products and an update state for
// the escape test and the floored, saturated update of z. A pixel that runs n
// passes (1 to MAX_PASSES) holds the engine until its result is registered,
// and that engine loop sets the sustained rate; the result beat carries the
// pass count minus one. The user writes registers only while no pixel is in
// flight; the block does not enforce this. There is no clearing pass after reset.
module julia_escape_time_top #(
   parameter int MAX_PASSES = jet_pkg::MAX_PASSES_DEF,
   parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF,
   parameter int INDEX_BITS = jet_pkg::INDEX_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: column[11:0], row[23:12].
   input  logic [2*jet_pkg::IDX_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: level[7:0].
   output logic [jet_pkg::LEVEL_W-1:0]      rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [jet_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [jet_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [jet_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic signed [jet_pkg::COORD_W-1:0] c_real_ff, c_imag_ff, origin_re_ff, origin_im_ff;
   logic [jet_pkg::STEP_W-1:0]         step_re_ff, step_im_ff;
   logic [jet_pkg::CSR_IDX_W-1:0]      reg_idx;
   logic                               wr_en;

   logic                fq_valid, fq_ready, qb_valid, qb_ready;
   jet_pkg::point_type  fq_data, qb_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[jet_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff    <= jet_pkg::C_REAL_RST;
         c_imag_ff    <= jet_pkg::C_IMAG_RST;
         origin_re_ff <= jet_pkg::ORIGIN_RE_RST;
         origin_im_ff <= jet_pkg::ORIGIN_IM_RST;
         step_re_ff   <= jet_pkg::STEP_RE_RST;
         step_im_ff   <= jet_pkg::STEP_IM_RST;
      end else if (wr_en) begin
         case (reg_idx)
            jet_pkg::REG_C_REAL:    c_real_ff    <= csr_pwdata;
            jet_pkg::REG_C_IMAG:    c_imag_ff    <= csr_pwdata;
            jet_pkg::REG_ORIGIN_RE: origin_re_ff <= csr_pwdata;
            jet_pkg::REG_ORIGIN_IM: origin_im_ff <= csr_pwdata;
            jet_pkg::REG_STEP_RE:   step_re_ff   <= csr_pwdata[jet_pkg::STEP_W-1:0];
            jet_pkg::REG_STEP_IM:   step_im_ff   <= csr_pwdata[jet_pkg::STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         jet_pkg::REG_C_REAL:    csr_prdata = c_real_ff;
         jet_pkg::REG_C_IMAG:    csr_prdata = c_imag_ff;
         jet_pkg::REG_ORIGIN_RE: csr_prdata = origin_re_ff;
         jet_pkg::REG_ORIGIN_IM: csr_prdata = origin_im_ff;
         jet_pkg::REG_STEP_RE:   csr_prdata = jet_pkg::CSR_DATA_W'(step_re_ff);
         jet_pkg::REG_STEP_IM:   csr_prdata = jet_pkg::CSR_DATA_W'(step_im_ff);
         default:                csr_prdata = '0;
      endcase
   end

   jet_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .origin_re  (origin_re_ff),
      .origin_im  (origin_im_ff),
      .step_re    (step_re_ff),
      .step_im    (step_im_ff),
      .pt_valid   (fq_valid),
      .pt_ready   (fq_ready),
      .pt_data    (fq_data)
   );

   jet_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   jet_back #(
      .MAX_PASSES (MAX_PASSES),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pt_valid   (qb_valid),
      .pt_ready   (qb_ready),
      .pt_data    (qb_data),
      .c_real     (c_real_ff),
      .c_imag     (c_imag_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_level  (rsp_tdata)
   );

endmodule

FILE: rtl/jet_front.sv
// Front end: accepts pixel beats and forms the saturated start point.
module jet_front #(
   parameter int INDEX_BITS = jet_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [2*jet_pkg::IDX_W-1:0]          req_tdata,
   input  logic signed [jet_pkg::COORD_W-1:0]   origin_re,
   input  logic signed [jet_pkg::COORD_W-1:0]   origin_im,
   input  logic [jet_pkg::STEP_W-1:0]           step_re,
   input  logic [jet_pkg::STEP_W-1:0]           step_im,
   output logic                                 pt_valid,
   input  logic                                 pt_ready,
   output jet_pkg::point_type                   pt_data
);

   localparam int IW = jet_pkg::IDX_W;
   localparam logic [IW-1:0] IDX_MASK =
      (INDEX_BITS >= IW) ? {IW{1'b1}} : IW'((1 << INDEX_BITS) - 1);

   logic                        valid_ff, valid_in;
   jet_pkg::point_type          pt_ff, pt_in;
   logic [IW-1:0]               col, row;
   logic [jet_pkg::SPAN_W-1:0]  col_span, row_span;
   logic signed [jet_pkg::PROD_W-1:0] zr_wide, zi_wide;
   logic                        take;

   assign req_tready = !valid_ff || pt_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      col      = req_tdata[IW-1:0] & IDX_MASK;
      row      = req_tdata[2*IW-1:IW] & IDX_MASK;
      col_span = jet_pkg::SPAN_W'(col) * jet_pkg::SPAN_W'(step_re);
      row_span = jet_pkg::SPAN_W'(row) * jet_pkg::SPAN_W'(step_im);
      zr_wide  = jet_pkg::PROD_W'(origin_re) + jet_pkg::PROD_W'(col_span);
      zi_wide  = jet_pkg::PROD_W'(origin_im) + jet_pkg::PROD_W'(row_span);
      pt_in.zr = jet_pkg::sat_coord(zr_wide);
      pt_in.zi = jet_pkg::sat_coord(zi_wide);
      if (take) begin
         valid_in = 1'b1;
      end else if (pt_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pt_ff <= pt_in;
      end
   end

   assign pt_valid = valid_ff;
   assign pt_data  = pt_ff;

endmodule

FILE: rtl/jet_queue.sv
// Short queue of start points between the front end and the iteration engine.
module jet_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  jet_pkg::point_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output jet_pkg::point_type  out_data
);

   jet_pkg::point_type               mem_ff [jet_pkg::QUEUE_DEPTH];
   logic [jet_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [jet_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [jet_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   logic                             push, pop;

   assign in_ready  = count_ff != jet_pkg::Q_CNT_W'(jet_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + jet_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + jet_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + jet_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - jet_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/jet_back.sv
// Iteration engine: runs z = z^2 + c on one start point and registers the level.
module jet_back #(
   parameter int MAX_PASSES = jet_pkg::MAX_PASSES_DEF,
   parameter int FRAC_BITS  = jet_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pt_valid,
   output logic                                 pt_ready,
   input  jet_pkg::point_type                   pt_data,
   input  logic signed [jet_pkg::COORD_W-1:0]   c_real,
   input  logic signed [jet_pkg::COORD_W-1:0]   c_imag,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [jet_pkg::LEVEL_W-1:0]          rsp_level
);

   localparam int PW    = jet_pkg::PROD_W;
   localparam int CNT_W = (MAX_PASSES > 2) ? $clog2(MAX_PASSES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PASSES - 1);
   localparam logic [PW-1:0]    LIMIT    = PW'(1) << (2 * FRAC_BITS + 2);

   jet_pkg::state_type                state_ff, state_in;
   logic signed [jet_pkg::COORD_W-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PW-1:0]              sr_ff, si_ff, cross_ff;
   logic signed [PW-1:0]              sr_in, si_in, cross_in;
   logic signed [PW-1:0]              diff, zr_wide, zi_wide;
   logic [PW-1:0]                     mag_sum;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [jet_pkg::LEVEL_W-1:0]       level_ff;
   logic                              keep_going, out_free;
   logic                              load, mul_en, upd_en, out_wr;

   // Escape test on the squares of the pass just computed, plus the pass cap.
   always_comb begin
      mag_sum    = sr_ff + si_ff;
      keep_going = (mag_sum < LIMIT) && (cnt_ff != CNT_LAST);
      out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jet_pkg::ST_IDLE: begin
            if (pt_valid) begin
               state_in = jet_pkg::ST_MUL;
            end
         end
         jet_pkg::ST_MUL: begin
            state_in = jet_pkg::ST_UPD;
         end
         jet_pkg::ST_UPD: begin
            state_in = keep_going ? jet_pkg::ST_MUL : jet_pkg::ST_DONE;
         end
         jet_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = jet_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jet_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pt_ready = 1'b0;
      load     = 1'b0;
      mul_en   = 1'b0;
      upd_en   = 1'b0;
      out_wr   = 1'b0;
      unique case (state_ff)
         jet_pkg::ST_IDLE: begin
            pt_ready = 1'b1;
            load     = pt_valid;
         end
         jet_pkg::ST_MUL: begin
            mul_en = 1'b1;
         end
         jet_pkg::ST_UPD: begin
            upd_en = 1'b1;
         end
         jet_pkg::ST_DONE: begin
            out_wr = out_free;
         end
         default: begin
            pt_ready = 1'b0;
         end
      endcase
   end

   // Products use the current z; the update stage floors and saturates them.
   always_comb begin
      sr_in    = PW'(zr_ff) * PW'(zr_ff);
      si_in    = PW'(zi_ff) * PW'(zi_ff);
      cross_in = PW'(zr_ff) * PW'(zi_ff);
      diff     = sr_ff - si_ff;
      zr_wide  = (diff >>> FRAC_BITS) + PW'(c_real);
      zi_wide  = (cross_ff >>> (FRAC_BITS - 1)) + PW'(c_imag);
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         zr_in  = pt_data.zr;
         zi_in  = pt_data.zi;
         cnt_in = '0;
      end else if (upd_en) begin
         zr_in = jet_pkg::sat_coord(zr_wide);
         zi_in = jet_pkg::sat_coord(zi_wide);
         if (keep_going) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (out_wr) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jet_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      cnt_ff <= cnt_in;
      if (mul_en) begin
         sr_ff    <= sr_in;
         si_ff    <= si_in;
         cross_ff <= cross_in;
      end
      if (out_wr) begin
         level_ff <= jet_pkg::LEVEL_W'(cnt_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_level  = level_ff;

   a_upd_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == jet_pkg::ST_UPD |-> $past(state_ff) == jet_pkg::ST_MUL)
      else $error("update stage entered without a product stage");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> state_ff == jet_pkg::ST_MUL && cnt_ff == '0)
      else $error("new point did not start at pass zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_wr |-> !rsp_valid_ff || rsp_tready)
      else $error("result written over a waiting result");

   a_repeat_counts: assert property (@(posedge clock) disable iff (reset)
      state_ff == jet_pkg::ST_MUL && $past(state_ff) == jet_pkg::ST_UPD |-> cnt_ff != '0)
      else $error("further pass without a pass count advance");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Julia escape-time block.
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 2 * jet_pkg::MAX_PASSES_DEF + 80;
   localparam int CHUNK          = 25;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [jet_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [jet_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam longint unsigned ESCAPE_BOUND = 64'd1 << (2 * jet_pkg::FRAC_BITS_DEF + 2);

   typedef struct {
      logic [jet_pkg::IDX_W-1:0]   col;
      logic [jet_pkg::IDX_W-1:0]   row;
      logic [jet_pkg::LEVEL_W-1:0] level;
   } pixel_job_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [2*jet_pkg::IDX_W-1:0]    req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [jet_pkg::LEVEL_W-1:0]    rsp_tdata;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [jet_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [jet_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [jet_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Shadow copy of the register file.
   logic signed [jet_pkg::COORD_W-1:0] c_re_cfg, c_im_cfg, org_re_cfg, org_im_cfg;
   logic [jet_pkg::STEP_W-1:0]         step_re_cfg, step_im_cfg;

   pixel_job_type pending_pixels[$];
   pixel_job_type expected_levels[$];
   pixel_job_type sent_pixel, due_pixel;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Sender idle and receiver stall percentages, used in rotation.
   int idle_plan[4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{33, 33}};

   julia_escape_time_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   function automatic longint clamp_coord(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Escape-time count for one pixel under the current shadow registers.
   function automatic logic [jet_pkg::LEVEL_W-1:0] escape_level(
      input logic [jet_pkg::IDX_W-1:0] col,
      input logic [jet_pkg::IDX_W-1:0] row);
      longint          base, span, zr, zi, sq_re, sq_im, cross_prod, c_re, c_im;
      longint unsigned mag;
      int              passes;
      base = org_re_cfg;
      span = col * step_re_cfg;
      zr   = clamp_coord(base + span);
      base = org_im_cfg;
      span = row * step_im_cfg;
      zi   = clamp_coord(base + span);
      c_re = c_re_cfg;
      c_im = c_im_cfg;
      mag    = 0;
      passes = 0;
      while (mag < ESCAPE_BOUND && passes < jet_pkg::MAX_PASSES_DEF) begin
         sq_re      = zr * zr;
         sq_im      = zi * zi;
         cross_prod = zr * zi;
         mag        = sq_re + sq_im;
         // Arithmetic shifts floor; the cross term is doubled by shifting one less.
         zi = clamp_coord((cross_prod >>> (jet_pkg::FRAC_BITS_DEF - 1)) + c_im);
         zr = clamp_coord(((sq_re - sq_im) >>> jet_pkg::FRAC_BITS_DEF) + c_re);
         passes++;
      end
      return jet_pkg::LEVEL_W'(passes - 1);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Pixel driver: holds a beat until it is taken, predicts at acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent_pixel = pending_pixels.pop_front();
            sent_pixel.level = escape_level(sent_pixel.col, sent_pixel.row);
            expected_levels.push_back(sent_pixel);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {pending_pixels[0].row, pending_pixels[0].col};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing pending, level %0d",
                                         rsp_tdata));
            end else begin
               due_pixel = expected_levels.pop_front();
               if (rsp_tdata !== due_pixel.level) begin
                  report_mismatch($sformatf("pixel (%0d,%0d): level %0d, expected %0d",
                                            due_pixel.col, due_pixel.row, rsp_tdata,
                                            due_pixel.level));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [jet_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [jet_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         jet_pkg::REG_C_REAL:    c_re_cfg    = value;
         jet_pkg::REG_C_IMAG:    c_im_cfg    = value;
         jet_pkg::REG_ORIGIN_RE: org_re_cfg  = value;
         jet_pkg::REG_ORIGIN_IM: org_im_cfg  = value;
         jet_pkg::REG_STEP_RE:   step_re_cfg = value[jet_pkg::STEP_W-1:0];
         jet_pkg::REG_STEP_IM:   step_im_cfg = value[jet_pkg::STEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_pixel(input int col, input int row);
      pixel_job_type job;
      job.col   = jet_pkg::IDX_W'(col);
      job.row   = jet_pkg::IDX_W'(row);
      job.level = '0;
      pending_pixels.push_back(job);
   endtask

   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || expected_levels.size() != 0)
         @(negedge clock);
   endtask

   // Random pixels, mostly inside the interesting window of span columns and rows.
   task automatic push_random(input int count, input int span);
      int plan_idx;
      plan_idx = 0;
      while (count > 0) begin
         @(negedge clock);
         send_idle_pct  = idle_plan[plan_idx][0];
         recv_stall_pct = idle_plan[plan_idx][1];
         plan_idx = (plan_idx + 1) % 4;
         for (int k = 0; k < CHUNK && count > 0; k++) begin
            if ($urandom_range(7) == 0) begin
               push_pixel($urandom_range(4095), $urandom_range(4095));
            end else begin
               push_pixel($urandom_range(span - 1), $urandom_range(span - 1));
            end
            count--;
         end
         while (pending_pixels.size() != 0) @(negedge clock);
      end
   endtask

   initial begin
      c_re_cfg    = jet_pkg::C_REAL_RST;
      c_im_cfg    = jet_pkg::C_IMAG_RST;
      org_re_cfg  = jet_pkg::ORIGIN_RE_RST;
      org_im_cfg  = jet_pkg::ORIGIN_IM_RST;
      step_re_cfg = jet_pkg::STEP_RE_RST;
      step_im_cfg = jet_pkg::STEP_IM_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset: corners, the window center and alternating bits.
      @(negedge clock);
      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(4095, 0);
      push_pixel(0, 4095);
      push_pixel(256, 256);
      push_pixel(255, 256);
      push_pixel(12'haaa, 12'h555);
      push_pixel(12'h555, 12'haaa);
      push_pixel(1, 1);
      push_pixel(511, 511);
      push_pixel(100, 300);
      push_pixel(300, 200);
      push_pixel(256, 0);
      push_pixel(0, 256);
      wait_drained();
      push_random(300, 512);
      wait_drained();

      // z stays at zero forever, so every pixel hits the pass cap.
      csr_write(jet_pkg::REG_C_REAL, 32'd0);
      csr_write(jet_pkg::REG_C_IMAG, 32'd0);
      csr_write(jet_pkg::REG_ORIGIN_RE, 32'd0);
      csr_write(jet_pkg::REG_ORIGIN_IM, 32'd0);
      csr_write(jet_pkg::REG_STEP_RE, 32'd0);
      csr_write(jet_pkg::REG_STEP_IM, 32'd0);
      @(negedge clock);
      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(12'h5a5, 12'ha5a);
      wait_drained();

      // With c at zero the bounded set is the unit disk; window -1.5..1.5.
      csr_write(jet_pkg::REG_ORIGIN_RE, -32'sd402653184);
      csr_write(jet_pkg::REG_ORIGIN_IM, -32'sd402653184);
      csr_write(jet_pkg::REG_STEP_RE, 32'd3145728);
      csr_write(jet_pkg::REG_STEP_IM, 32'd3145728);
      push_random(150, 256);
      wait_drained();

      // Extremes: start points saturate, updates saturate, bit 31 of a step is dropped.
      csr_write(jet_pkg::REG_C_REAL, 32'h8000_0000);
      csr_write(jet_pkg::REG_C_IMAG, 32'h7fff_ffff);
      csr_write(jet_pkg::REG_ORIGIN_RE, 32'h7fff_ffff);
      csr_write(jet_pkg::REG_ORIGIN_IM, 32'h8000_0000);
      csr_write(jet_pkg::REG_STEP_RE, 32'hffff_ffff);
      csr_write(jet_pkg::REG_STEP_IM, 32'd1);
      csr_write(REG_SPARE_LO, 32'h1234_5678);
      csr_write(REG_SPARE_HI, 32'hffff_ffff);
      @(negedge clock);
      push_pixel(0, 0);
      push_pixel(4095, 4095);
      push_pixel(1, 4095);
      push_pixel(4095, 1);
      wait_drained();
      push_random(50, 4096);
      wait_drained();
      csr_write(jet_pkg::REG_ORIGIN_RE, 32'h8000_0000);
      csr_write(jet_pkg::REG_ORIGIN_IM, 32'h7fff_ffff);
      csr_write(jet_pkg::REG_STEP_IM, 32'h7fff_ffff);
      push_random(50, 4096);
      wait_drained();

      // c = 0.285 + 0.01i over -1.5..1.5 by -1.0..1.0.
      csr_write(jet_pkg::REG_C_REAL, 32'd76504105);
      csr_write(jet_pkg::REG_C_IMAG, 32'd2684355);
      csr_write(jet_pkg::REG_ORIGIN_RE, -32'sd402653184);
      csr_write(jet_pkg::REG_ORIGIN_IM, -32'sd268435456);
      csr_write(jet_pkg::REG_STEP_RE, 32'd1572864);
      csr_write(jet_pkg::REG_STEP_IM, 32'd1048576);
      push_random(300, 512);
      wait_drained();

      // c = -0.4 + 0.6i.
      csr_write(jet_pkg::REG_C_REAL, -32'sd107374182);
      csr_write(jet_pkg::REG_C_IMAG, 32'd161061274);
      csr_write(jet_pkg::REG_ORIGIN_RE, -32'sd429496730);
      csr_write(jet_pkg::REG_STEP_RE, 32'd1677722);
      push_random(300, 512);
      wait_drained();

      // Back to the power-on values.
      csr_write(jet_pkg::REG_C_REAL, jet_pkg::C_REAL_RST);
      csr_write(jet_pkg::REG_C_IMAG, jet_pkg::C_IMAG_RST);
      csr_write(jet_pkg::REG_ORIGIN_RE, jet_pkg::ORIGIN_RE_RST);
      csr_write(jet_pkg::REG_ORIGIN_IM, jet_pkg::ORIGIN_IM_RST);
      csr_write(jet_pkg::REG_STEP_RE, 32'(jet_pkg::STEP_RE_RST));
      csr_write(jet_pkg::REG_STEP_IM, 32'(jet_pkg::STEP_IM_RST));
      push_random(100, 512);
      wait_drained();

      // Give a stray extra result beat time to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/jet_pkg.sv
rtl/jet_front.sv
rtl/jet_queue.sv
rtl/jet_back.sv
rtl/julia_escape_time_top.sv
tb/tb.sv
